>>> rtl/binary_max_heap_queue_core_defines.svh
// ---------------------------------------------------------------------------
// Heap queue assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_CORE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMHQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heap queue check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define BMHQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heap queue check failed one cycle later");

`endif

>>> rtl/bmhq_pkg.sv
// ---------------------------------------------------------------------------
// Heap queue package
// Sizes, types and controller/datapath interface structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int CAPACITY    = 128;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int COUNT_W     = $clog2(CAPACITY + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [ADDR_W-1:0]             addr_t;
  typedef logic [COUNT_W-1:0]            cnt_t;
  typedef logic [COUNT_W:0]              kid_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_START,
    DP_PLACE,
    DP_RD_PARENT,
    DP_UP_STEP,
    DP_RD_LAST,
    DP_LOAD_LAST,
    DP_RD_KIDS,
    DP_DN_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic go_up;
    logic go_down;
    logic at_root;
    logic up_greater;
    logic no_child;
    logic dn_stay;
  } status_t;

endpackage

>>> rtl/binary_max_heap_queue_core.sv
// ---------------------------------------------------------------------------
// Binary max-heap priority queue
// Push signed words or pop the maximum; one result word per input word.
// ---------------------------------------------------------------------------
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   in      | in_valid / in_stall | kind, value
//   out     | out_valid/out_stall | accepted, popped_value, top_value,
//           |                     | entry_count, is_empty, is_full
//
// A push climbs while its value exceeds the parent's; a pop moves the last
// entry to the root and sinks it toward the larger child until it settles. A
// rejected word or a pop of the last entry skips the sift and goes straight
// to the result. Each level costs one registered heap RAM read and one write.
// Reset clears the entry count and the result valid; heap contents need no sweep.
// in_stall is high while a word is in work; a waiting result holds its last cycle.
//
`timescale 1ns / 1ps

module binary_max_heap_queue_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             kind,
  input  bmhq_pkg::value_t value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             accepted,
  output bmhq_pkg::value_t popped_value,
  output bmhq_pkg::value_t top_value,
  output bmhq_pkg::cnt_t   entry_count,
  output logic             is_empty,
  output logic             is_full
);

  // Command and status are the only link between sequencing and storage.
  bmhq_pkg::cmd_t    cmd;
  bmhq_pkg::status_t status;

  // Sequence the sift loops and own both handshakes.
  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold the heap, the count, the moving entry and the result word.
  bmhq_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .kind         (kind),
    .value        (value),
    .accepted     (accepted),
    .popped_value (popped_value),
    .top_value    (top_value),
    .entry_count  (entry_count),
    .is_empty     (is_empty),
    .is_full      (is_full)
  );

endmodule

>>> rtl/bmhq_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
  output logic [WIDTH-1:0]         rd_a_data,
  input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic [WIDTH-1:0]         rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

>>> rtl/bmhq_datapath.sv
// ---------------------------------------------------------------------------
// Heap queue datapath
// Heap store, entry count, sift position, compares and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmhq_datapath (
  input  logic               clk,
  input  logic               rst,
  input  bmhq_pkg::cmd_t     cmd,
  output bmhq_pkg::status_t  status,
  input  logic               kind,
  input  bmhq_pkg::value_t   value,
  output logic               accepted,
  output bmhq_pkg::value_t   popped_value,
  output bmhq_pkg::value_t   top_value,
  output bmhq_pkg::cnt_t     entry_count,
  output logic               is_empty,
  output logic               is_full
);

  bmhq_pkg::cnt_t   count;
  bmhq_pkg::cnt_t   pos;
  bmhq_pkg::value_t hold_val;
  bmhq_pkg::value_t popped_reg;
  bmhq_pkg::value_t top_reg;
  logic             op_ok;
  logic             pop_op;

  bmhq_pkg::kid_t   kid_l;
  bmhq_pkg::kid_t   kid_r;
  bmhq_pkg::kid_t   best_pos;
  bmhq_pkg::addr_t  rd_a_addr;
  bmhq_pkg::addr_t  rd_b_addr;
  bmhq_pkg::addr_t  wr_addr;
  bmhq_pkg::value_t rd_a;
  bmhq_pkg::value_t rd_b;
  bmhq_pkg::value_t wr_data;
  bmhq_pkg::value_t best1;
  bmhq_pkg::value_t dn_val;
  logic             wr_en;
  logic             full;
  logic             empty;
  logic             has_right;
  logic             up_greater;
  logic             l_gt;
  logic             r_gt;

  assign full  = (count == bmhq_pkg::cnt_t'(bmhq_pkg::CAPACITY));
  assign empty = (count == '0);

  assign kid_l     = {pos, 1'b0};
  assign kid_r     = kid_l + bmhq_pkg::kid_t'(1);
  assign has_right = (kid_r <= bmhq_pkg::kid_t'(count));

  // Read addresses are 0-based; heap positions are 1-based.
  always_comb begin
    unique case (cmd.op)
      bmhq_pkg::DP_RD_LAST: rd_a_addr = bmhq_pkg::addr_t'(count);
      bmhq_pkg::DP_RD_KIDS: rd_a_addr = bmhq_pkg::addr_t'(kid_l - bmhq_pkg::kid_t'(1));
      default:              rd_a_addr = bmhq_pkg::addr_t'((pos >> 1) - bmhq_pkg::cnt_t'(1));
    endcase
  end
  assign rd_b_addr = bmhq_pkg::addr_t'(kid_l);
  assign wr_addr   = bmhq_pkg::addr_t'(pos - bmhq_pkg::cnt_t'(1));

  assign up_greater = (hold_val > rd_a);
  assign l_gt       = (rd_a > hold_val);
  assign best1      = l_gt ? rd_a : hold_val;
  assign r_gt       = has_right && (rd_b > best1);
  assign dn_val     = r_gt ? rd_b : best1;
  assign best_pos   = r_gt ? kid_r : kid_l;

  always_comb begin
    wr_en   = 1'b0;
    wr_data = hold_val;
    unique case (cmd.op)
      bmhq_pkg::DP_PLACE: begin
        wr_en = 1'b1;
      end
      bmhq_pkg::DP_UP_STEP: begin
        wr_en   = 1'b1;
        wr_data = up_greater ? rd_a : hold_val;
      end
      bmhq_pkg::DP_DN_STEP: begin
        wr_en   = 1'b1;
        wr_data = dn_val;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  bmhq_ram #(
    .WIDTH (bmhq_pkg::VALUE_WIDTH),
    .DEPTH (bmhq_pkg::CAPACITY)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b)
  );

  assign status.go_up      = !kind && !full;
  assign status.go_down    = kind && (count > bmhq_pkg::cnt_t'(1));
  assign status.at_root    = (pos == bmhq_pkg::cnt_t'(1));
  assign status.up_greater = up_greater;
  assign status.no_child   = (kid_l > bmhq_pkg::kid_t'(count));
  assign status.dn_stay    = !l_gt && !r_gt;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.op == bmhq_pkg::DP_START) begin
      if (!kind && !full) begin
        count <= count + bmhq_pkg::cnt_t'(1);
      end else if (kind && !empty) begin
        count <= count - bmhq_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      bmhq_pkg::DP_START: begin
        hold_val   <= value;
        pos        <= kind ? bmhq_pkg::cnt_t'(1) : count + bmhq_pkg::cnt_t'(1);
        op_ok      <= kind ? !empty : !full;
        pop_op     <= kind;
        popped_reg <= top_reg;
      end
      bmhq_pkg::DP_UP_STEP: begin
        if (up_greater) begin
          pos <= pos >> 1;
        end
      end
      bmhq_pkg::DP_LOAD_LAST: begin
        hold_val <= rd_a;
      end
      bmhq_pkg::DP_DN_STEP: begin
        if (!status.dn_stay) begin
          pos <= bmhq_pkg::cnt_t'(best_pos);
        end
      end
      default: begin
        pos <= pos;
      end
    endcase

    // Mirror the root so the top never costs a read.
    if (wr_en && (pos == bmhq_pkg::cnt_t'(1))) begin
      top_reg <= wr_data;
    end

    if (cmd.out_load) begin
      accepted     <= op_ok;
      popped_value <= (op_ok && pop_op) ? popped_reg : '0;
      top_value    <= empty ? '0 : top_reg;
      entry_count  <= count;
      is_empty     <= empty;
      is_full      <= full;
    end
  end

endmodule

>>> rtl/bmhq_ctrl.sv
// ---------------------------------------------------------------------------
// Heap queue controller
// Sequences push sift-up, pop sift-down and the result handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmhq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  bmhq_pkg::status_t status,
  output bmhq_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_POP_RD,
    S_POP_LD,
    S_DN_CHK,
    S_DN_CMP,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.op       = bmhq_pkg::DP_IDLE;
    cmd.out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = bmhq_pkg::DP_START;
          if (status.go_up) begin
            state_next = S_UP_CHK;
          end else if (status.go_down) begin
            state_next = S_POP_RD;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_UP_CHK: begin
        if (status.at_root) begin
          cmd.op     = bmhq_pkg::DP_PLACE;
          state_next = S_FINISH;
        end else begin
          cmd.op     = bmhq_pkg::DP_RD_PARENT;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.op     = bmhq_pkg::DP_UP_STEP;
        state_next = status.up_greater ? S_UP_CHK : S_FINISH;
      end
      S_POP_RD: begin
        cmd.op     = bmhq_pkg::DP_RD_LAST;
        state_next = S_POP_LD;
      end
      S_POP_LD: begin
        cmd.op     = bmhq_pkg::DP_LOAD_LAST;
        state_next = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (status.no_child) begin
          cmd.op     = bmhq_pkg::DP_PLACE;
          state_next = S_FINISH;
        end else begin
          cmd.op     = bmhq_pkg::DP_RD_KIDS;
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        cmd.op     = bmhq_pkg::DP_DN_STEP;
        state_next = status.dn_stay ? S_FINISH : S_DN_CHK;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/bmhq_checker.sv
// ---------------------------------------------------------------------------
// Heap queue checker
// Port-level checks on result words and input handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_max_heap_queue_core_defines.svh"

module bmhq_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             accepted,
  input bmhq_pkg::value_t popped_value,
  input bmhq_pkg::value_t top_value,
  input bmhq_pkg::cnt_t   entry_count,
  input logic             is_empty,
  input logic             is_full
);

  `BMHQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `BMHQ_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(top_value) && $stable(entry_count))
  `BMHQ_ASSERT_SAME(a_empty_flag, out_valid, is_empty == (entry_count == '0))
  `BMHQ_ASSERT_SAME(a_empty_top, out_valid && is_empty, (top_value == '0) && !is_full)
  `BMHQ_ASSERT_SAME(a_reject_zero, out_valid && !accepted, popped_value == '0)

endmodule

bind binary_max_heap_queue_core bmhq_checker u_bmhq_checker (.*);

>>> verif/binary_max_heap_queue_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Heap queue core testbench
// Drives push and pop words through the valid/stall input channel with bursty
// timing and a stalling result sink, keeps its own max-heap to predict every
// result word, and compares each accepted result field by field.
// ---------------------------------------------------------------------------

module binary_max_heap_queue_core_tb;

  import bmhq_pkg::*;

  // Operation codes carried on the kind port.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam value_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  localparam int DIR_ROWS    = 23;
  localparam int RAND_WORDS  = 1300;
  localparam int DRAIN_WAIT  = 40;    // well past the slowest word
  localparam int LIMIT_NS    = 5_000_000;

  // One result word, in port order.
  typedef struct packed {
    logic   accepted;
    value_t popped;
    value_t top;
    cnt_t   cnt;
    logic   empty;
    logic   full;
  } heap_result_t;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    logic         op;
    value_t       val;
    logic         typed;
    heap_result_t want;
  } heap_row_t;

  typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIX} seg_mode_t;
  typedef enum {SINK_OPEN, SINK_LIGHT, SINK_HALF, SINK_CHOKED} sink_mode_t;

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   in_valid  = 1'b0;
  logic   in_stall;
  logic   kind      = OP_PUSH;
  value_t value     = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic   accepted;
  value_t popped_value;
  value_t top_value;
  cnt_t   entry_count;
  logic   is_empty;
  logic   is_full;

  binary_max_heap_queue_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .popped_value (popped_value),
    .top_value    (top_value),
    .entry_count  (entry_count),
    .is_empty     (is_empty),
    .is_full      (is_full)
  );

  always #5 clk = ~clk;

  // Stimulus words, built up front and walked by the driver.
  logic         word_op    [$];
  value_t       word_val   [$];
  logic         word_typed [$];
  heap_result_t word_want  [$];

  // Shadow heap for prediction, 1-based like the hardware heap positions.
  value_t       shadow_heap [1:CAPACITY];
  int unsigned  shadow_n = 0;

  heap_result_t due_results [$];
  int           words_taken = 0;
  int           results_seen = 0;
  int           errors = 0;

  // Apply one word to the shadow heap and return the result it must produce.
  function automatic heap_result_t next_heap_result(input logic op, input value_t v);
    heap_result_t r;
    int unsigned  pos;
    int unsigned  best;
    int unsigned  kid;
    value_t       t;
    logic         settled;
    r = '0;
    if (op == OP_PUSH) begin
      if (shadow_n < CAPACITY) begin
        shadow_n++;
        shadow_heap[shadow_n] = v;
        pos = shadow_n;
        // Climb only past a strictly smaller parent.
        while (pos > 1 && shadow_heap[pos] > shadow_heap[pos / 2]) begin
          t = shadow_heap[pos];
          shadow_heap[pos] = shadow_heap[pos / 2];
          shadow_heap[pos / 2] = t;
          pos = pos / 2;
        end
        r.accepted = 1'b1;
      end
    end else if (shadow_n > 0) begin
      r.popped = shadow_heap[1];
      shadow_heap[1] = shadow_heap[shadow_n];
      shadow_n--;
      pos = 1;
      settled = 1'b0;
      // Sink toward the larger child; the left child wins a tie.
      while (!settled && 2 * pos <= shadow_n) begin
        best = pos;
        kid  = 2 * pos;
        if (shadow_heap[kid] > shadow_heap[best]) best = kid;
        if (kid + 1 <= shadow_n && shadow_heap[kid + 1] > shadow_heap[best]) best = kid + 1;
        if (best == pos) begin
          settled = 1'b1;
        end else begin
          t = shadow_heap[pos];
          shadow_heap[pos] = shadow_heap[best];
          shadow_heap[best] = t;
          pos = best;
        end
      end
      r.accepted = 1'b1;
    end
    if (shadow_n > 0) r.top = shadow_heap[1];
    r.cnt   = cnt_t'(shadow_n);
    r.empty = (shadow_n == 0);
    r.full  = (shadow_n == CAPACITY);
    return r;
  endfunction

  // Mix of value classes: wide random, clustered small values that force
  // ties, and the signed extremes, zero and all ones.
  function automatic value_t pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return value_t'($urandom);
    if (sel < 8) return value_t'($urandom_range(0, 7)) - value_t'(3);
    case ($urandom_range(0, 3))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic queue_word(input logic op, input value_t v, input logic typed,
                            input heap_result_t want, inout int unsigned depth);
    word_op.push_back(op);
    word_val.push_back(v);
    word_typed.push_back(typed);
    word_want.push_back(want);
    // Track the occupancy so random segments can aim at full and empty.
    if (op == OP_PUSH) begin
      if (depth < CAPACITY) depth++;
    end else if (depth > 0) begin
      depth--;
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  // Predict on every accepted input word and check every accepted result word.
  always @(posedge clk) begin : watch
    heap_result_t pred;
    heap_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pred = next_heap_result(kind, value);
        // Directed rows with a typed answer take that answer; the shadow heap
        // still advances so later rows stay in step.
        if (word_typed[words_taken]) due_results.push_back(word_want[words_taken]);
        else due_results.push_back(pred);
        words_taken++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $display("%0t ns: result word with nothing expected, actual accepted %b top %h",
                   $time, accepted, top_value);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("accepted",     32'(want.accepted), 32'(accepted));
          check_field("popped_value", want.popped,        popped_value);
          check_field("top_value",    want.top,           top_value);
          check_field("entry_count",  32'(want.cnt),      32'(entry_count));
          check_field("is_empty",     32'(want.empty),    32'(is_empty));
          check_field("is_full",      32'(want.full),     32'(is_full));
        end
      end
    end
  end

  // Result sink: switch among open, light, half and choked stall patterns.
  sink_mode_t  sink_mode = SINK_OPEN;
  int unsigned sink_left = 0;

  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_left = $urandom_range(16, 160);
    end else begin
      sink_left = sink_left - 1;
    end
    case (sink_mode)
      SINK_OPEN:  out_stall <= 1'b0;
      SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      SINK_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
      default:    out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Hard stop in case the block hangs.
  initial begin
    #LIMIT_NS;
    $display("binary_max_heap_queue_core_tb: errors");
    $finish;
  end

  initial begin : drive
    heap_row_t    dir_tab [DIR_ROWS];
    heap_result_t none;
    int unsigned  depth;
    int           rand_count;
    seg_mode_t    seg;
    int           seg_len;
    int           push_pct;
    int           extra;
    int           burst;
    int           gap;
    int           i;
    logic         op;

    none  = '0;
    depth = 0;

    // Directed table: pop on empty after reset, both signed extremes, the
    // value ignored on pop, equal values, and draining back to empty.
    dir_tab[0]  = '{OP_POP,  '0,      1'b1, '{1'b0, '0,      '0,      cnt_t'(0), 1'b1, 1'b0}};
    dir_tab[1]  = '{OP_PUSH, VAL_MAX, 1'b1, '{1'b1, '0,      VAL_MAX, cnt_t'(1), 1'b0, 1'b0}};
    dir_tab[2]  = '{OP_PUSH, VAL_MIN, 1'b1, '{1'b1, '0,      VAL_MAX, cnt_t'(2), 1'b0, 1'b0}};
    dir_tab[3]  = '{OP_POP,  '0,      1'b1, '{1'b1, VAL_MAX, VAL_MIN, cnt_t'(1), 1'b0, 1'b0}};
    dir_tab[4]  = '{OP_POP,  '0,      1'b1, '{1'b1, VAL_MIN, '0,      cnt_t'(0), 1'b1, 1'b0}};
    dir_tab[5]  = '{OP_POP,  '1,      1'b1, '{1'b0, '0,      '0,      cnt_t'(0), 1'b1, 1'b0}};
    dir_tab[6]  = '{OP_PUSH, value_t'(5),  1'b0, none};
    dir_tab[7]  = '{OP_PUSH, value_t'(5),  1'b0, none};
    dir_tab[8]  = '{OP_PUSH, value_t'(5),  1'b0, none};
    dir_tab[9]  = '{OP_PUSH, '1,           1'b0, none};
    dir_tab[10] = '{OP_PUSH, '0,           1'b0, none};
    dir_tab[11] = '{OP_PUSH, value_t'(6),  1'b0, none};
    dir_tab[12] = '{OP_PUSH, value_t'(32'h5555_5555), 1'b0, none};
    dir_tab[13] = '{OP_PUSH, value_t'(32'haaaa_aaaa), 1'b0, none};
    for (i = 14; i < 22; i++) dir_tab[i] = '{OP_POP, '0, 1'b0, none};
    dir_tab[22] = '{OP_POP,  '0,      1'b1, '{1'b0, '0,      '0,      cnt_t'(0), 1'b1, 1'b0}};

    for (i = 0; i < DIR_ROWS; i++)
      queue_word(dir_tab[i].op, dir_tab[i].val, dir_tab[i].typed, dir_tab[i].want, depth);

    // Random part in segments: fill past full, drain past empty, or a mix
    // with a per-segment push bias.
    rand_count = 0;
    while (rand_count < RAND_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1:    seg = SEG_FILL;
        2, 3:    seg = SEG_DRAIN;
        default: seg = SEG_MIX;
      endcase
      if (seg == SEG_FILL) begin
        extra = $urandom_range(1, 3);
        while (depth < CAPACITY) begin
          queue_word(OP_PUSH, pick_value(), 1'b0, none, depth);
          rand_count++;
        end
        repeat (extra) begin
          queue_word(OP_PUSH, pick_value(), 1'b0, none, depth);
          rand_count++;
        end
      end else if (seg == SEG_DRAIN) begin
        extra = $urandom_range(1, 2);
        while (depth > 0) begin
          queue_word(OP_POP, pick_value(), 1'b0, none, depth);
          rand_count++;
        end
        repeat (extra) begin
          queue_word(OP_POP, pick_value(), 1'b0, none, depth);
          rand_count++;
        end
      end else begin
        seg_len  = $urandom_range(20, 60);
        push_pct = $urandom_range(30, 70);
        repeat (seg_len) begin
          op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
          queue_word(op, pick_value(), 1'b0, none, depth);
          rand_count++;
        end
      end
    end

    // Hold reset, then release it on a falling edge.
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Send words in bursts; between bursts drop valid across a gap of falling edges
    // so valid is never lowered and raised in the same step.
    burst = 0;
    for (i = 0; i < word_op.size(); i++) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16) : $urandom_range(1, 3);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
      end
      in_valid <= 1'b1;
      kind     <= word_op[i];
      value    <= word_val[i];
      burst--;
      // Hold the word until the block takes it.
      @(posedge clk);
      while (in_stall) @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    // Wait for every expected result, then watch for strays.
    while (due_results.size() != 0 || results_seen < words_taken) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("binary_max_heap_queue_core_tb: clean");
    end else begin
      $display("binary_max_heap_queue_core_tb: errors");
    end
    $finish;
  end

endmodule
